### hw/rtl/plt_pkg.sv
// shared constants, register indexes, op codes and saturation helper
`timescale 1ns / 1ps
package plt_pkg;

  localparam int POINTS_DEF = 64;
  localparam int MUL_W      = 33;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_EVAL   = 3'd1;
  localparam logic [2:0] OP_UPD_X  = 3'd2;
  localparam logic [2:0] OP_UPD_M  = 3'd3;
  localparam logic [2:0] OP_SLOPE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LRATE    = 2'd2;

  localparam logic [31:0] X_ORIGIN_RST = 32'd0;
  localparam logic [31:0] INV_STEP_RST = 32'd65536;
  localparam logic [15:0] LRATE_RST    = 16'd655;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] res;
    if (v[33] && !(&v[32:31])) begin
      res = 32'h8000_0000;
    end else if (!v[33] && (|v[32:31])) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/plt_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module plt_mul (
  input  logic                                   clk,
  input  logic signed [plt_pkg::MUL_W-1:0]       a,
  input  logic signed [plt_pkg::MUL_W-1:0]       b,
  output logic signed [2*plt_pkg::MUL_W-1:0]     prod
);

  logic signed [2*plt_pkg::MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

### hw/rtl/piecewise_linear_table_learner.sv
// top level: point table, sequencer and datapath around the shared multiplier
//
// Learned function of one variable held as POINTS equally spaced Q16.16 points.
// Input: an op with x, value and point_index is taken at a clock edge where
// start is high and busy is low. Ops: load point, evaluate, update at x,
// update at the remembered segment, slope.
// Result: out_valid is high for exactly one cycle with out_result and
// out_out_of_range; the receiver cannot stall, so every result is taken then.
// Each accepted beat gives exactly one result beat.
// Evaluate and slope locate the segment, read both neighbor points, take their
// difference and multiply; the updates scale the value by the rate and split it
// over both points (update at x locates first), then read and write both points.
// busy stays high until the result cycle, in which the next item can already be
// taken. The steps are set by the single multiplier (one product per cycle,
// registered) and the single read port of the table, read once per neighbor point.
// Configuration: cfg_we writes register cfg_index with cfg_wdata at once.
// Reset (synchronous, rst_n low) returns the sequencer to idle, restores the
// register defaults and clears the remembered segment and fraction; the point
// table keeps its contents and must be loaded before it is read.
`timescale 1ns / 1ps
module piecewise_linear_table_learner #(
  parameter int POINTS = plt_pkg::POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     in_op,
  input  logic signed [31:0]             in_x,
  input  logic signed [31:0]             in_value,
  input  logic [5:0]                     in_point_index,
  output logic                           out_valid,
  output logic signed [31:0]             out_result,
  output logic                           out_out_of_range,
  input  logic                           cfg_we,
  input  logic [plt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  localparam int IDX_W = (POINTS > 2) ? $clog2(POINTS) : 1;
  localparam int MW    = plt_pkg::MUL_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOC  = 4'd1;
  localparam logic [3:0] ST_SEG  = 4'd2;
  localparam logic [3:0] ST_MR   = 4'd3;
  localparam logic [3:0] ST_MF   = 4'd4;
  localparam logic [3:0] ST_MG   = 4'd5;
  localparam logic [3:0] ST_RD0  = 4'd6;
  localparam logic [3:0] ST_RD1  = 4'd7;
  localparam logic [3:0] ST_DIF  = 4'd8;
  localparam logic [3:0] ST_MUL  = 4'd9;
  localparam logic [3:0] ST_WR1  = 4'd10;
  localparam logic [3:0] ST_WR0  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [31:0]        x_origin_r, inv_step_r;
  logic [15:0]        lrate_r;
  logic [IDX_W-1:0]   last_seg_r;
  logic [15:0]        last_frac_r;

  logic [2:0]         op_r;
  logic signed [31:0] x_r, val_r;
  logic [IDX_W-1:0]   seg_r;
  logic [15:0]        frac_r;
  logic               flag_r;
  logic signed [31:0] d_r, r_r, l_r, y0_r;
  logic signed [32:0] diff_r;
  logic [32:0]        mag_r;
  logic               neg_r;

  logic               out_valid_r, out_oor_r;
  logic [31:0]        out_result_r;

  logic [31:0]        mem [POINTS];
  logic [31:0]        rdata_r;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               mem_we;
  logic [31:0]        mem_wdata;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;

  logic               accept, direct_done, load_ok;
  logic [31:0]        pidx_ext, idx;
  logic signed [32:0] dx;
  logic [16:0]        frac_c;
  logic signed [33:0] ev_sum;
  logic [48:0]        slope_q;
  logic [31:0]        slope_res, fin_res;
  logic [IDX_W-1:0]   seg_c;
  logic [15:0]        frac_loc;
  logic               flag_c;

  assign accept      = start && !busy;
  assign busy        = (state_r != ST_IDLE);
  assign pidx_ext    = 32'(in_point_index);
  assign load_ok     = (pidx_ext < 32'(POINTS));
  assign direct_done = accept && !(in_op == plt_pkg::OP_EVAL || in_op == plt_pkg::OP_UPD_X ||
                                   in_op == plt_pkg::OP_UPD_M || in_op == plt_pkg::OP_SLOPE);

  assign dx     = {x_r[31], x_r} - {x_origin_r[31], x_origin_r};
  assign idx    = prod[63:32];
  assign frac_c = plt_pkg::ONE_Q16 - {1'b0, frac_r};

  // segment and fraction from the located product
  always_comb begin
    if (dx[32]) begin
      seg_c    = '0;
      frac_loc = 16'h0000;
      flag_c   = 1'b1;
    end else if (idx >= 32'(POINTS - 1)) begin
      seg_c    = IDX_W'(POINTS - 2);
      frac_loc = 16'hFFFF;
      flag_c   = 1'b1;
    end else begin
      seg_c    = idx[IDX_W-1:0];
      frac_loc = prod[31:16];
      flag_c   = 1'b0;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOC: begin
        mul_a = {1'b0, dx[31:0]};
        mul_b = {1'b0, inv_step_r};
      end
      ST_MR: begin
        mul_a = {val_r[31], val_r};
        mul_b = MW'(lrate_r);
      end
      ST_MF: begin
        mul_a = {prod[47], prod[47:16]};
        mul_b = MW'(frac_r);
      end
      ST_MG: begin
        mul_a = {d_r[31], d_r};
        mul_b = MW'(frac_c);
      end
      ST_MUL: begin
        if (op_r == plt_pkg::OP_SLOPE) begin
          mul_a = {1'b0, mag_r[31:0]};
          mul_b = {1'b0, inv_step_r};
        end else begin
          mul_a = diff_r;
          mul_b = MW'(frac_r);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  plt_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // final result
  assign ev_sum  = {{2{y0_r[31]}}, y0_r} + {prod[48], prod[48:16]};
  assign slope_q = {1'b0, prod[63:16]} + (mag_r[32] ? {1'b0, inv_step_r, 16'h0000} : 49'd0);

  always_comb begin
    if (neg_r) begin
      slope_res = (slope_q > 49'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - slope_q[31:0]);
    end else begin
      slope_res = (slope_q > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : slope_q[31:0];
    end
    case (op_r)
      plt_pkg::OP_EVAL:  fin_res = plt_pkg::sat32(ev_sum);
      plt_pkg::OP_SLOPE: fin_res = slope_res;
      default:           fin_res = 32'd0;
    endcase
  end

  // table ports
  assign rd_addr = (state_r == ST_RD1) ? IDX_W'(seg_r + 1'b1) : seg_r;

  always_comb begin
    mem_we    = 1'b0;
    wr_addr   = pidx_ext[IDX_W-1:0];
    mem_wdata = in_value;
    case (state_r)
      ST_IDLE: begin
        mem_we = accept && (in_op == plt_pkg::OP_LOAD) && load_ok;
      end
      ST_WR1: begin
        mem_we    = 1'b1;
        wr_addr   = IDX_W'(seg_r + 1'b1);
        mem_wdata = plt_pkg::sat32({{2{rdata_r[31]}}, rdata_r} + {{2{r_r[31]}}, r_r});
      end
      ST_WR0: begin
        mem_we    = 1'b1;
        wr_addr   = seg_r;
        mem_wdata = plt_pkg::sat32({{2{y0_r[31]}}, y0_r} + {{2{l_r[31]}}, l_r});
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            plt_pkg::OP_EVAL, plt_pkg::OP_UPD_X, plt_pkg::OP_SLOPE: state_nxt = ST_LOC;
            plt_pkg::OP_UPD_M:                                     state_nxt = ST_MR;
            default:                                               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOC:  state_nxt = ST_SEG;
      ST_SEG:  state_nxt = (op_r == plt_pkg::OP_UPD_X) ? ST_MR : ST_RD0;
      ST_MR:   state_nxt = ST_MF;
      ST_MF:   state_nxt = ST_MG;
      ST_MG:   state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1: begin
        if (op_r == plt_pkg::OP_EVAL || op_r == plt_pkg::OP_SLOPE) begin
          state_nxt = ST_DIF;
        end else begin
          state_nxt = ST_WR1;
        end
      end
      ST_DIF:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_WR1:  state_nxt = ST_WR0;
      ST_WR0:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_origin_r  <= plt_pkg::X_ORIGIN_RST;
      inv_step_r  <= plt_pkg::INV_STEP_RST;
      lrate_r     <= plt_pkg::LRATE_RST;
      last_seg_r  <= '0;
      last_frac_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= direct_done || (state_r == ST_FIN);
      if (cfg_we) begin
        case (cfg_index)
          plt_pkg::CFG_X_ORIGIN: x_origin_r <= cfg_wdata;
          plt_pkg::CFG_INV_STEP: inv_step_r <= cfg_wdata;
          plt_pkg::CFG_LRATE:    lrate_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (state_r == ST_SEG && op_r == plt_pkg::OP_EVAL) begin
        last_seg_r  <= seg_c;
        last_frac_r <= frac_loc;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= in_op;
          x_r    <= in_x;
          val_r  <= in_value;
          seg_r  <= last_seg_r;
          frac_r <= last_frac_r;
          flag_r <= 1'b0;
        end
        out_result_r <= 32'd0;
        out_oor_r    <= 1'b0;
      end
      ST_SEG: begin
        seg_r  <= seg_c;
        frac_r <= frac_loc;
        flag_r <= flag_c;
      end
      ST_MF:  d_r <= prod[47:16];
      ST_MG:  r_r <= prod[47:16];
      ST_RD0: l_r <= prod[47:16];
      ST_RD1: y0_r <= rdata_r;
      ST_DIF: begin
        diff_r <= {rdata_r[31], rdata_r} - {y0_r[31], y0_r};
        if ($signed(rdata_r) < $signed(y0_r)) begin
          mag_r <= {y0_r[31], y0_r} - {rdata_r[31], rdata_r};
          neg_r <= 1'b1;
        end else begin
          mag_r <= {rdata_r[31], rdata_r} - {y0_r[31], y0_r};
          neg_r <= 1'b0;
        end
      end
      ST_FIN: begin
        out_result_r <= fin_res;
        out_oor_r    <= flag_r;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_out_of_range = out_oor_r;

  a_fin_gives_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_valid)
    else $error("finishing item gave no result beat");

  a_load_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == plt_pkg::OP_LOAD) |=> (out_valid && out_result == 32'd0 &&
                                               !out_out_of_range && !busy))
    else $error("load did not return a zero result beat");

  a_seg_in_table : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD0) |-> (32'(seg_r) <= 32'(POINTS - 2)))
    else $error("segment beyond last table segment");

  a_no_beat_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != ST_LOC && state_r != ST_MR) |-> !out_valid)
    else $error("result beat while item still at work");

endmodule

### verif/piecewise_linear_table_learner_test.sv
// self-checking testbench for the piecewise-linear table learner
`timescale 1ns / 1ps
module piecewise_linear_table_learner_test;

  localparam int POINTS = plt_pkg::POINTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic [2:0] op;
    logic signed [31:0] x;
    logic signed [31:0] value;
    logic [5:0] pidx;
    logic [plt_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [31:0] cfg_data;
    int gap;
  } stim_entry_t;

  typedef struct {
    logic [31:0] result;
    logic flag;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_value = '0;
  logic [5:0] in_point_index = '0;
  logic out_valid;
  logic signed [31:0] out_result;
  logic out_out_of_range;
  logic cfg_we = 1'b0;
  logic [plt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  stim_entry_t stim_q[$];
  beat_t want_q[$];

  // shadow copy of the block's registers and state
  logic signed [31:0] m_org = plt_pkg::X_ORIGIN_RST;
  logic [31:0] m_inv = plt_pkg::INV_STEP_RST;
  logic [15:0] m_lrate = plt_pkg::LRATE_RST;
  logic signed [31:0] points_model [POINTS];
  int unsigned m_seg = 0;
  logic [15:0] m_frac = '0;

  int errors = 0;
  int beats_checked = 0;
  int clamp_count = 0;
  int cfg_count = 0;
  int op_count [8];
  int hold = 0;
  logic armed = 1'b0;
  logic quiet_stretch = 1'b0;
  int idle_cycles = 0;

  piecewise_linear_table_learner u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_x             (in_x),
    .in_value         (in_value),
    .in_point_index   (in_point_index),
    .out_valid        (out_valid),
    .out_result       (out_result),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] clip32(input longint v);
    if (v > I32_MAX) begin
      return 32'h7FFF_FFFF;
    end
    if (v < I32_MIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic find_segment(input logic signed [31:0] x,
                                        output int unsigned seg,
                                        output logic [15:0] frac);
    longint d;
    logic [63:0] p;
    d = longint'(x) - longint'(m_org);
    if (d < 0) begin
      seg = 0;
      frac = '0;
      return 1'b1;
    end
    p = {32'd0, d[31:0]} * {32'd0, m_inv};
    if (p[63:32] >= POINTS - 1) begin
      seg = POINTS - 2;
      frac = 16'hFFFF;
      return 1'b1;
    end
    seg = p[63:32];
    frac = p[31:16];
    return 1'b0;
  endfunction

  function automatic void bump_points(input int unsigned seg, input logic [15:0] frac,
                                      input longint delta);
    longint scaled, right, left;
    scaled = (delta * longint'(m_lrate)) >>> 16;
    right = (scaled * longint'(frac)) >>> 16;
    left = (scaled * (64'sd65536 - longint'(frac))) >>> 16;
    points_model[seg + 1] = clip32(longint'(points_model[seg + 1]) + right);
    points_model[seg] = clip32(longint'(points_model[seg]) + left);
  endfunction

  function automatic beat_t predict_beat(input stim_entry_t s);
    beat_t b;
    int unsigned seg;
    logic [15:0] frac;
    longint y0, y1, diff;
    logic [63:0] mag, q;
    b.result = '0;
    b.flag = 1'b0;
    case (s.op)
      plt_pkg::OP_LOAD: begin
        points_model[s.pidx] = s.value;
      end
      plt_pkg::OP_EVAL: begin
        b.flag = find_segment(s.x, seg, frac);
        m_seg = seg;
        m_frac = frac;
        y0 = longint'(points_model[seg]);
        y1 = longint'(points_model[seg + 1]);
        b.result = clip32(y0 + (((y1 - y0) * longint'(frac)) >>> 16));
      end
      plt_pkg::OP_UPD_X: begin
        b.flag = find_segment(s.x, seg, frac);
        bump_points(seg, frac, longint'(s.value));
      end
      plt_pkg::OP_UPD_M: begin
        bump_points(m_seg, m_frac, longint'(s.value));
      end
      plt_pkg::OP_SLOPE: begin
        b.flag = find_segment(s.x, seg, frac);
        diff = longint'(points_model[seg + 1]) - longint'(points_model[seg]);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        q = (mag * {32'd0, m_inv}) >> 16;
        if (diff < 0) begin
          b.result = (q > 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        end else begin
          b.result = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
      end
      default: begin
      end
    endcase
    op_count[s.op]++;
    if (b.flag) begin
      clamp_count++;
    end
    return b;
  endfunction

  function automatic void apply_cfg(input logic [plt_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      plt_pkg::CFG_X_ORIGIN: m_org = data;
      plt_pkg::CFG_INV_STEP: m_inv = data;
      plt_pkg::CFG_LRATE: m_lrate = data[15:0];
      default: begin
      end
    endcase
    cfg_count++;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    stim_entry_t head;
    logic go;
    logic we;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      armed = 1'b0;
    end else begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        want_q.push_back(predict_beat(stim_q[0]));
        void'(stim_q.pop_front());
        go = 1'b0;
        armed = 1'b0;
      end
      if (!go && stim_q.size() != 0) begin
        head = stim_q[0];
        if (!armed) begin
          hold = head.gap;
          armed = 1'b1;
        end
        if (hold != 0) begin
          hold--;
        end else begin
          case (head.kind)
            ENT_ITEM: begin
              go = 1'b1;
              in_op <= head.op;
              in_x <= head.x;
              in_value <= head.value;
              in_point_index <= head.pidx;
            end
            ENT_CFG: begin
              if (want_q.size() == 0 && !busy) begin
                we = 1'b1;
                cfg_index <= head.cfg_idx;
                cfg_wdata <= head.cfg_data;
                apply_cfg(head.cfg_idx, head.cfg_data);
                void'(stim_q.pop_front());
                armed = 1'b0;
              end
            end
            default: begin
              if (want_q.size() == 0 && !busy) begin
                void'(stim_q.pop_front());
                armed = 1'b0;
              end
            end
          endcase
        end
      end
      start <= go;
      cfg_we <= we;
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid) begin
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", out_result));
      end else begin
        want = want_q.pop_front();
        beats_checked++;
        if (out_result !== want.result) begin
          report_mismatch($sformatf("result %h, want %h", out_result, want.result));
        end
        if (out_out_of_range !== want.flag) begin
          report_mismatch($sformatf("out_of_range %b, want %b", out_out_of_range, want.flag));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_item(input logic [2:0] op, input logic [31:0] x, input logic [31:0] value,
                          input logic [5:0] pidx);
    stim_entry_t e;
    e.kind = ENT_ITEM;
    e.op = op;
    e.x = x;
    e.value = value;
    e.pidx = pidx;
    e.cfg_idx = '0;
    e.cfg_data = '0;
    e.gap = quiet_stretch ? 0 : $urandom_range(0, 11);
    stim_q.push_back(e);
  endtask

  task automatic add_cfg(input logic [plt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    stim_entry_t e;
    e.kind = ENT_CFG;
    e.op = plt_pkg::OP_LOAD;
    e.x = '0;
    e.value = '0;
    e.pidx = '0;
    e.cfg_idx = idx;
    e.cfg_data = data;
    e.gap = $urandom_range(0, 3);
    stim_q.push_back(e);
  endtask

  task automatic add_drain();
    stim_entry_t e;
    e.kind = ENT_DRAIN;
    e.op = plt_pkg::OP_LOAD;
    e.x = '0;
    e.value = '0;
    e.pidx = '0;
    e.cfg_idx = '0;
    e.cfg_data = '0;
    e.gap = 0;
    stim_q.push_back(e);
  endtask

  function automatic logic [31:0] pick_value();
    int small_val;
    small_val = int'($urandom_range(0, 33554431)) - 16777216;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return small_val;
    endcase
  endfunction

  // mostly inside the table, sometimes below, just past the end or anywhere
  function automatic logic [31:0] pick_x(input logic signed [31:0] org, input logic [31:0] inv);
    logic [63:0] span, r;
    int unsigned mode;
    span = (64'd63 << 32) / {32'd0, inv};
    r = {$urandom, $urandom} % (span + 64'd2);
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      return $urandom;
    end
    if (mode == 1) begin
      return clip32(longint'(org) - longint'($urandom_range(1, 32'h00FF_FFFF)));
    end
    return clip32(longint'(org) + longint'(r));
  endfunction

  task automatic random_phase(input logic [31:0] org, input logic [31:0] inv,
                              input logic [15:0] lr, input int n);
    int made;
    int unsigned pick;
    logic paused;
    logic [31:0] xv;
    add_drain();
    add_cfg(plt_pkg::CFG_X_ORIGIN, org);
    add_cfg(plt_pkg::CFG_INV_STEP, inv);
    add_cfg(plt_pkg::CFG_LRATE, {16'd0, lr});
    made = 0;
    paused = 1'b0;
    while (made < n) begin
      if (made % 40 < 2) begin
        quiet_stretch = ($urandom_range(0, 3) == 0);
      end
      if (!paused && made >= n / 2) begin
        add_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      xv = pick_x(org, inv);
      if (pick < 40) begin
        add_item(plt_pkg::OP_EVAL, xv, $urandom, 6'($urandom));
        add_item(plt_pkg::OP_UPD_M, $urandom, pick_value(), 6'($urandom));
        made += 2;
      end else if (pick < 55) begin
        add_item(plt_pkg::OP_UPD_X, xv, pick_value(), 6'($urandom));
        made++;
      end else if (pick < 70) begin
        add_item(plt_pkg::OP_SLOPE, xv, $urandom, 6'($urandom));
        made++;
      end else if (pick < 85) begin
        add_item(plt_pkg::OP_LOAD, $urandom, pick_value(), 6'($urandom));
        made++;
      end else if (pick < 96) begin
        add_item(plt_pkg::OP_EVAL, xv, $urandom, 6'($urandom));
        made++;
      end else begin
        add_item(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), $urandom, $urandom,
                 6'($urandom));
        made++;
      end
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    logic [31:0] fill;
    foreach (op_count[i]) begin
      op_count[i] = 0;
    end
    // every point loaded before anything reads the table
    for (int i = 0; i < POINTS; i++) begin
      if (i == 1 || i == POINTS - 1) begin
        fill = 32'h7FFF_FFFF;
      end else if (i == 0 || i == 2 || i == POINTS - 2) begin
        fill = 32'h8000_0000;
      end else begin
        fill = pick_value();
      end
      add_item(plt_pkg::OP_LOAD, $urandom, fill, 6'(i));
    end
    // directed part on the reset settings: point i sits at x = i
    add_item(plt_pkg::OP_EVAL, 32'h0000_8000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_SLOPE, 32'h0000_8000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_SLOPE, 32'h0001_4000, 32'hFFFF_FFFF, 6'd63);
    add_item(plt_pkg::OP_SLOPE, 32'h003E_0005, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'hFFFF_FFFF, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'h8000_0000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'h7FFF_FFFF, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'h003F_0000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'h003E_FFFF, 32'h0, 6'd0);
    add_item(plt_pkg::OP_UPD_M, 32'h0, 32'h7FFF_FFFF, 6'd0);
    add_item(plt_pkg::OP_UPD_X, 32'h0001_8000, 32'h8000_0000, 6'd0);
    add_item(plt_pkg::OP_UPD_X, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 6'd0);
    add_item(plt_pkg::OP_UPD_X, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
    add_item(plt_pkg::OP_UPD_M, 32'h0, 32'h8000_0000, 6'd0);
    add_item(OP_SPARE_A, $urandom, $urandom, 6'($urandom));
    add_item(OP_SPARE_B, $urandom, $urandom, 6'($urandom));
    add_item(OP_SPARE_C, $urandom, $urandom, 6'($urandom));
    add_item(plt_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'h0, 6'd63);
    add_item(plt_pkg::OP_LOAD, 32'h0, 32'h0001_0000, 6'd0);
    add_item(plt_pkg::OP_SLOPE, 32'h8000_0000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_SLOPE, 32'h7FFF_FFFF, 32'h0, 6'd0);
    add_item(plt_pkg::OP_EVAL, 32'h0001_0000, 32'h0, 6'd0);
    add_item(plt_pkg::OP_UPD_M, 32'h0, 32'h0010_0000, 6'd0);
    random_phase(32'h0, 32'h0001_0000, 16'd655, 300);
    random_phase(32'h8000_0000, 32'h1, 16'hFFFF, 300);
    random_phase(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0, 300);
    random_phase(32'hFFE0_0000, 32'h0000_8000, 16'h8000, 300);
    random_phase($urandom, $urandom_range(32'h0000_1000, 32'h0400_0000),
                 16'($urandom), 300);
    random_phase($urandom, 32'h0040_0000, 16'($urandom), 300);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() != 0 || want_q.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("ops taken: load %0d, evaluate %0d, update at x %0d, update remembered %0d, "
             , op_count[plt_pkg::OP_LOAD], op_count[plt_pkg::OP_EVAL],
             op_count[plt_pkg::OP_UPD_X], op_count[plt_pkg::OP_UPD_M]);
    $display("slope %0d, reserved %0d; %0d clamped, %0d beats checked, %0d register writes",
             op_count[plt_pkg::OP_SLOPE],
             op_count[OP_SPARE_A] + op_count[OP_SPARE_B] + op_count[OP_SPARE_C],
             clamp_count, beats_checked, cfg_count);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
